### rtl/pinhole_ray_direction_macros.svh
// assertion macros for the pinhole ray direction block
// expects clk and rst in the scope of use
`ifndef PINHOLE_RAY_DIRECTION_MACROS_SVH
`define PINHOLE_RAY_DIRECTION_MACROS_SVH

// same-cycle implication
`define PRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/prd_pkg.sv
// shared types and constants for the pinhole ray direction block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package prd_pkg;

  // output fraction bits
  localparam int DirFracBits = 14;

  // datapath widths
  localparam int SumWidth    = 38;               // rotated component, signed
  localparam int MagWidth    = 37;               // magnitude of rotated component
  localparam int PosWidth    = 6;                // msb position of magnitude
  localparam int NormWidth   = 31;               // normalized magnitude
  localparam int NormMsb     = 30;               // target msb after normalizing
  localparam int RootWidth   = 32;
  localparam int SqrtStages  = 32;
  localparam int QuoWidth    = DirFracBits + 1;
  localparam int DivStages   = DirFracBits + 1;
  localparam int DivWidth    = DirFracBits + 33;
  localparam int AddrWidth   = 6;

  // register reset values
  localparam logic [15:0] HalfWidthReset   = 16'd5120;
  localparam logic [15:0] HalfHeightReset  = 16'd3840;
  localparam logic [19:0] FocalReset       = 20'd9271;
  localparam logic [47:0] BasisRightReset  = 48'h0000_0000_4000;
  localparam logic [47:0] BasisUpReset     = 48'h0000_4000_0000;
  localparam logic [47:0] BasisBackReset   = 48'h4000_0000_0000;

  // register index codes
  typedef enum logic [2:0] {
    RegHalfWidth  = 3'd0,
    RegHalfHeight = 3'd1,
    RegFocal      = 3'd2,
    RegBasisRight = 3'd3,
    RegBasisUp    = 3'd4,
    RegBasisBack  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_dir_t;

  // per-lane sign flags and one zero flag for the whole vector
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } prd_sign_t;

  // data riding along the square root pipe
  typedef struct packed {
    logic [2:0][NormWidth-1:0] m;
    prd_sign_t                 sgn;
  } prd_side_t;

endpackage

`default_nettype wire

### rtl/prd_isqrt.sv
// pipelined 64-bit integer square root, one result bit per stage
// depends on prd_pkg
`timescale 1ns / 1ps
`default_nettype none

module prd_isqrt
  import prd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [63:0]          n,
  input  prd_side_t            in_side,
  output logic                 out_valid,
  output logic [RootWidth-1:0] root,
  output prd_side_t            out_side
);

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } sq_t;

  logic [63:0] n_q    [1:SqrtStages];
  logic [63:0] res_q  [1:SqrtStages];
  prd_side_t   side_q [1:SqrtStages];
  logic        vld_q  [1:SqrtStages];

  // one digit of the root
  function automatic sq_t sqrt_step(input logic [63:0] nv, input logic [63:0] rv,
                                    input int idx);
    logic [63:0] bit_v;
    logic [63:0] trial;
    sq_t         o;
    bit_v = 64'd1 << (62 - 2 * idx);
    trial = rv + bit_v;
    if (nv >= trial) begin
      o.n   = nv - trial;
      o.res = (rv >> 1) + bit_v;
    end else begin
      o.n   = nv;
      o.res = rv >> 1;
    end
    return o;
  endfunction

  for (genvar i = 0; i < SqrtStages; i++) begin : g_stage
    logic [63:0] n_in;
    logic [63:0] res_in;
    prd_side_t   side_in;
    logic        vld_in;

    // stage input: the port beat for the first stage
    if (i == 0) begin : g_head
      assign n_in    = n;
      assign res_in  = 64'd0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_tail
      assign n_in    = n_q[i];
      assign res_in  = res_q[i];
      assign side_in = side_q[i];
      assign vld_in  = vld_q[i];
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_in;
      end
    end

    // root digit
    always_ff @(posedge clk) begin
      {n_q[i+1], res_q[i+1]} <= sqrt_step(n_in, res_in, i);
      side_q[i+1]            <= side_in;
    end
  end

  assign out_valid = vld_q[SqrtStages];
  assign root      = res_q[SqrtStages][RootWidth-1:0];
  assign out_side  = side_q[SqrtStages];

endmodule

`default_nettype wire

### rtl/prd_div.sv
// pipelined rounded divide of three lanes by a shared root
// one quotient bit per stage; depends on prd_pkg
`timescale 1ns / 1ps
`default_nettype none

module prd_div
  import prd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [RootWidth-1:0]          r,
  input  prd_side_t                     in_side,
  output logic                          out_valid,
  output logic [2:0][QuoWidth-1:0]      q,
  output prd_sign_t                     out_sgn
);

  typedef struct packed {
    logic [DivWidth-1:0] rem;
    logic [QuoWidth-1:0] q;
  } dv_t;

  logic [DivWidth-1:0] rem_q [1:DivStages][0:2];
  logic [QuoWidth-1:0] quo_q [1:DivStages][0:2];
  logic [RootWidth-1:0] r_q  [1:DivStages];
  prd_sign_t            sg_q [1:DivStages];
  logic                 vld_q [1:DivStages];

  // one restoring step at quotient bit sh
  function automatic dv_t div_step(input logic [DivWidth-1:0] rm,
                                   input logic [RootWidth-1:0] rv,
                                   input logic [QuoWidth-1:0] qv, input int sh);
    logic [DivWidth-1:0] d;
    dv_t                 o;
    d   = DivWidth'(rv) << sh;
    o.q = qv;
    if (rm >= d) begin
      o.rem   = rm - d;
      o.q[sh] = 1'b1;
    end else begin
      o.rem = rm;
    end
    return o;
  endfunction

  // quotient bit stages, msb first
  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [2:0][DivWidth-1:0] rem_in;
    logic [2:0][QuoWidth-1:0] quo_in;
    logic [RootWidth-1:0]     r_in;
    prd_sign_t                sg_in;
    logic                     vld_in;

    if (s == 0) begin : g_head
      // numerator: m scaled up plus half the divisor
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = (DivWidth'(in_side.m[k]) << DirFracBits) + DivWidth'(r >> 1);
          quo_in[k] = '0;
        end
      end
      assign r_in   = r;
      assign sg_in  = in_side.sgn;
      assign vld_in = in_valid;
    end else begin : g_tail
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = rem_q[s][k];
          quo_in[k] = quo_q[s][k];
        end
      end
      assign r_in   = r_q[s];
      assign sg_in  = sg_q[s];
      assign vld_in = vld_q[s];
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_in;
      end
    end

    // one quotient bit per lane
    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        {rem_q[s+1][k], quo_q[s+1][k]} <=
          div_step(rem_in[k], r_in, quo_in[k], DirFracBits - s);
      end
      r_q[s+1]  <= r_in;
      sg_q[s+1] <= sg_in;
    end
  end

  assign out_valid = vld_q[DivStages];
  assign out_sgn   = sg_q[DivStages];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q[k] = quo_q[DivStages][k];
    end
  end

endmodule

`default_nettype wire

### rtl/pinhole_ray_direction.sv
// top level of the pinhole camera ray direction generator
// depends on prd_pkg, prd_isqrt, prd_div and pinhole_ray_direction_macros.svh
//
// Takes one pixel position per clock and returns the unit world-space ray
// direction in Q1.14. busy is always low, so start may be held high every
// cycle; done pulses for one cycle with the result, which passes through the
// 8 front stages, the 32-stage square root, the one-bit-per-stage divider
// and the output register. The receiver cannot stall results, and none is
// needed. Configuration goes over the APB port at byte address 8*index and
// must only be changed while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "pinhole_ray_direction_macros.svh"

module pinhole_ray_direction
  import prd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pixel_t               pixel,
  output logic                 done,
  output ray_dir_t             dir,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  // configuration registers
  logic [15:0] half_width;
  logic [15:0] half_height;
  logic [19:0] focal_length;
  logic [47:0] basis_right;
  logic [47:0] basis_up;
  logic [47:0] basis_back;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = reg_idx_t'(paddr[AddrWidth-1:3]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width   <= HalfWidthReset;
      half_height  <= HalfHeightReset;
      focal_length <= FocalReset;
      basis_right  <= BasisRightReset;
      basis_up     <= BasisUpReset;
      basis_back   <= BasisBackReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        RegHalfWidth:  half_width   <= pwdata[15:0];
        RegHalfHeight: half_height  <= pwdata[15:0];
        RegFocal:      focal_length <= pwdata[19:0];
        RegBasisRight: basis_right  <= pwdata[47:0];
        RegBasisUp:    basis_up     <= pwdata[47:0];
        RegBasisBack:  basis_back   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      RegHalfWidth:  prdata = 64'(half_width);
      RegHalfHeight: prdata = 64'(half_height);
      RegFocal:      prdata = 64'(focal_length);
      RegBasisRight: prdata = 64'(basis_right);
      RegBasisUp:    prdata = 64'(basis_up);
      RegBasisBack:  prdata = 64'(basis_back);
      default:       prdata = 64'd0;
    endcase
  end

  // pipeline valid bits, stages 1 to 8
  logic [8:1] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[7:1], start & ~busy};
    end
  end

  // stage 1: camera-space vector
  logic signed [16:0] cx1, cy1;
  logic signed [20:0] cz1;
  always_ff @(posedge clk) begin
    cx1 <= $signed({1'b0, pixel.pixel_x}) - $signed({1'b0, half_width});
    cy1 <= $signed({1'b0, half_height}) - $signed({1'b0, pixel.pixel_y});
    cz1 <= -$signed({1'b0, focal_length});
  end

  // stage 2: nine basis products
  logic signed [32:0] pr2 [0:2];
  logic signed [32:0] pu2 [0:2];
  logic signed [36:0] pb2 [0:2];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pr2[k] <= cx1 * $signed(basis_right[16*k +: 16]);
      pu2[k] <= cy1 * $signed(basis_up[16*k +: 16]);
      pb2[k] <= cz1 * $signed(basis_back[16*k +: 16]);
    end
  end

  // stage 3: world components
  logic signed [SumWidth-1:0] w3 [0:2];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      w3[k] <= SumWidth'(pr2[k]) + SumWidth'(pu2[k]) + SumWidth'(pb2[k]);
    end
  end

  // stage 4: magnitudes, signs and the largest magnitude
  logic [MagWidth-1:0] m_abs [0:2];
  logic [MagWidth-1:0] m_max;
  logic [MagWidth-1:0] m4 [0:2];
  logic [MagWidth-1:0] mx4;
  logic [2:0]          neg4;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_abs[k] = w3[k][SumWidth-1] ? MagWidth'(-w3[k]) : MagWidth'(w3[k]);
    end
    m_max = (m_abs[0] > m_abs[1]) ? m_abs[0] : m_abs[1];
    if (m_abs[2] > m_max) begin
      m_max = m_abs[2];
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m4[k]   <= m_abs[k];
      neg4[k] <= w3[k][SumWidth-1];
    end
    mx4 <= m_max;
  end

  // stage 5: msb position of the largest magnitude
  logic [PosWidth-1:0] msb_pos;
  logic [PosWidth-1:0] p5;
  logic [MagWidth-1:0] m5 [0:2];
  logic [2:0]          neg5;
  logic                zero5;
  always_comb begin
    msb_pos = '0;
    for (int b = 0; b < MagWidth; b++) begin
      if (mx4[b]) begin
        msb_pos = PosWidth'(b);
      end
    end
  end
  always_ff @(posedge clk) begin
    p5    <= msb_pos;
    m5    <= m4;
    neg5  <= neg4;
    zero5 <= (mx4 == '0);
  end

  // stage 6: common shift so the largest lands in bit 30
  logic [MagWidth-1:0]  m_sh [0:2];
  logic [NormWidth-1:0] m6 [0:2];
  logic [2:0]           neg6;
  logic                 zero6;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (p5 > PosWidth'(NormMsb)) begin
        m_sh[k] = m5[k] >> (p5 - PosWidth'(NormMsb));
      end else begin
        m_sh[k] = m5[k] << (PosWidth'(NormMsb) - p5);
      end
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m6[k] <= m_sh[k][NormWidth-1:0];
    end
    neg6  <= neg5;
    zero6 <= zero5;
  end

  // stage 7: squares
  logic [63:0]          sq7 [0:2];
  logic [NormWidth-1:0] m7 [0:2];
  logic [2:0]           neg7;
  logic                 zero7;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq7[k] <= 64'(m6[k]) * 64'(m6[k]);
    end
    m7    <= m6;
    neg7  <= neg6;
    zero7 <= zero6;
  end

  // stage 8: squared length
  logic [63:0] n8;
  prd_side_t   side8;
  always_ff @(posedge clk) begin
    n8 <= sq7[0] + sq7[1] + sq7[2];
    for (int k = 0; k < 3; k++) begin
      side8.m[k] <= m7[k];
    end
    side8.sgn.neg  <= neg7;
    side8.sgn.zero <= zero7;
  end

  // square root
  logic                 sq_valid;
  logic [RootWidth-1:0] root;
  prd_side_t            sq_side;
  prd_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[8]),
    .n         (n8),
    .in_side   (side8),
    .out_valid (sq_valid),
    .root      (root),
    .out_side  (sq_side)
  );

  // rounded divide
  logic                     dv_valid;
  logic [2:0][QuoWidth-1:0] quo;
  prd_sign_t                dv_sgn;
  prd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .r         (root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .q         (quo),
    .out_sgn   (dv_sgn)
  );

  // output beat: apply signs, zero vector gives zero
  logic [63:0] sv [0:2];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_sgn.zero) begin
        sv[k] = 64'd0;
      end else if (dv_sgn.neg[k]) begin
        sv[k] = 64'd0 - 64'(quo[k]);
      end else begin
        sv[k] = 64'(quo[k]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end
  always_ff @(posedge clk) begin
    dir.dir_x <= sv[0][15:0];
    dir.dir_y <= sv[1][15:0];
    dir.dir_z <= sv[2][15:0];
  end

  // checks; a zero vector divides by a zero root, so its quotient is not bounded
  `PRD_ASSERT_IMP(a_norm_range, vld[6] && !zero6,
    (m6[0][NormMsb] || m6[1][NormMsb] || m6[2][NormMsb]), "normalize missed bit 30")
  `PRD_ASSERT_IMP(a_quo_unit, dv_valid && !dv_sgn.zero,
    (quo[0] <= (QuoWidth'(1) << DirFracBits)) && (quo[1] <= (QuoWidth'(1) << DirFracBits))
    && (quo[2] <= (QuoWidth'(1) << DirFracBits)), "quotient above one")
  `PRD_ASSERT_NXT(a_zero_out, dv_valid && dv_sgn.zero,
    done && dir.dir_x == 16'sd0 && dir.dir_y == 16'sd0 && dir.dir_z == 16'sd0,
    "zero vector gave nonzero beat")

endmodule

`default_nettype wire
